// ===== rtl/mcdt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mcdt_pkg;
    localparam int NumChannels = 16;
    localparam int TimeBits = 32;
    localparam int ChBits = 4;

    typedef logic [ChBits-1:0] ch_t;
    typedef logic [TimeBits-1:0] tm_t;

    typedef enum logic [2:0] {
        ACT_CHECK   = 3'd0,
        ACT_PERIOD  = 3'd1,
        ACT_START_R = 3'd2,
        ACT_START_O = 3'd3,
        ACT_DISABLE = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  channel;
        logic [31:0] period_ms;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [15:0] fire_mask;
        logic        hw_stop;
        logic        hw_start;
        logic [31:0] reload_value;
        logic [31:0] nearest_deadline;
        logic        any_active;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN0,
        ST_DECIDE,
        ST_FIRE,
        ST_CATCH,
        ST_SCAN1,
        ST_RELOAD,
        ST_MUL,
        ST_SCAN2,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan_step;
        logic fire_step;
        logic catch_start;
        logic catch_step;
        logic apply;
        logic set_stop;
        logic set_start;
        logic reload_sel_next;
        logic mul;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic    scan_last;
        logic    found;
        logic    due;
        logic    fire_need_catch;
        logic    catch_done;
        logic    earlier;
        action_t action;
        logic    valid_ch;
    } sts_t;
endpackage
`default_nettype wire

// ===== rtl/mcdt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcdt_ctrl
    import mcdt_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   in_go,
    input  wire   out_free,
    input  sts_t  sts,
    output cmd_t  cmd,
    output logic  busy,
    output logic  out_vld
);
    state_t state_reg, state_next;
    logic   phase_reg, phase_next;   // 0: start decision scan, 1: post-fire scan
    logic   out_vld_reg, out_vld_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        out_vld_next = out_vld_reg;
        if (out_vld_reg && out_free)
            out_vld_next = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (in_go)
                    state_next = ST_SCAN0;
            ST_SCAN0:
                if (sts.scan_last)
                    state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                case (sts.action)
                    ACT_CHECK:
                        state_next = (sts.found && sts.due) ? ST_FIRE : ST_SCAN2;
                    ACT_START_R, ACT_START_O:
                        state_next = sts.valid_ch ? ST_RELOAD : ST_SCAN2;
                    default:
                        state_next = ST_SCAN2;
                endcase
                phase_next = 1'b0;
            end
            ST_FIRE:
                if (sts.fire_need_catch)
                    state_next = ST_CATCH;
                else if (sts.scan_last)
                    state_next = ST_SCAN1;
            ST_CATCH:
                if (sts.catch_done)
                    state_next = sts.scan_last ? ST_SCAN1 : ST_FIRE;
            ST_SCAN1:
                if (sts.scan_last)
                begin
                    state_next = ST_RELOAD;
                    phase_next = 1'b1;
                end
            ST_RELOAD:
                state_next = ST_MUL;
            ST_MUL:
                state_next = ST_SCAN2;
            ST_SCAN2:
                if (sts.scan_last && !out_vld_next)
                    state_next = ST_OUT;
            ST_OUT:
            begin
                state_next   = ST_IDLE;
                out_vld_next = 1'b1;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load     = in_go;
                cmd.scan_clr = in_go;
            end
            ST_SCAN0:
                cmd.scan_step = 1'b1;
            ST_DECIDE:
            begin
                // a start keeps the pending nearest for its comparison
                cmd.scan_clr = !((sts.action inside {ACT_START_R, ACT_START_O})
                                 && sts.valid_ch);
                cmd.apply    = 1'b1;
                cmd.set_stop = (sts.action == ACT_CHECK) && sts.found && sts.due;
            end
            ST_FIRE:
            begin
                cmd.fire_step   = !sts.fire_need_catch;
                cmd.catch_start = sts.fire_need_catch;
                cmd.scan_clr    = !sts.fire_need_catch && sts.scan_last;
            end
            ST_CATCH:
            begin
                cmd.catch_step = 1'b1;
                cmd.scan_clr   = sts.catch_done && sts.scan_last;
            end
            ST_SCAN1:
                cmd.scan_step = 1'b1;
            ST_RELOAD:
            begin
                cmd.scan_clr        = 1'b1;
                cmd.reload_sel_next = !phase_reg;
                cmd.set_start       = phase_reg ? sts.found : sts.earlier;
                cmd.set_stop        = !phase_reg && sts.earlier;
            end
            ST_MUL:
                cmd.mul = 1'b1;
            ST_SCAN2:
                cmd.scan_step = !(sts.scan_last && out_vld_next);
            ST_OUT:
                cmd.out_load = 1'b1;
            default:
                cmd = '0;
        endcase
    end

    assign out_vld = out_vld_reg;

    a_out_only_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |-> $past(state_reg) == ST_SCAN2)
        else $error("output without final scan");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load)
        else $error("load while busy");
    a_out_vld_set: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT |=> out_vld_reg)
        else $error("result not raised");
endmodule
`default_nettype wire

// ===== rtl/mcdt_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mcdt_dp
    import mcdt_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  in_word_t   in_word,
    input  wire  [7:0] ticks,
    input  cmd_t       cmd,
    output sts_t       sts,
    output out_word_t  out_word
);
    tm_t       period_reg [NumChannels];
    tm_t       deadline_reg [NumChannels];
    logic [NumChannels-1:0] active_reg, repeat_reg;

    in_word_t  item_reg;
    ch_t       idx_reg;
    logic      found_reg;
    tm_t       best_reg;
    logic [15:0] fire_reg;
    logic      stop_reg, start_reg;
    tm_t       dt_reg;
    logic [31:0] reload_reg;
    tm_t       cu_d_reg;
    logic      cu_wrap_reg;
    out_word_t out_reg;

    tm_t       now_w, next_w, cu_sum;
    logic [TimeBits:0] cu_ext;
    logic      hit_w;
    logic [39:0] prod_w;
    logic      last_w;

    assign now_w  = item_reg.now_ms;
    assign next_w = now_w + period_reg[item_reg.channel];
    assign last_w = (idx_reg == ch_t'(NumChannels - 1));
    assign hit_w  = active_reg[idx_reg] && (deadline_reg[idx_reg] <= now_w);
    assign cu_ext = {1'b0, cu_d_reg} + {1'b0, period_reg[idx_reg]};
    assign cu_sum = cu_ext[TimeBits-1:0];
    assign prod_w = {8'd0, dt_reg} * {32'd0, ticks};

    always_comb
    begin
        sts.scan_last       = last_w;
        sts.found           = found_reg;
        sts.due             = best_reg <= now_w;
        sts.fire_need_catch = hit_w && repeat_reg[idx_reg];
        // a step that wraps past the top of time ends the catch-up
        sts.catch_done      = (cu_d_reg >= now_w) || cu_wrap_reg;
        sts.earlier         = !found_reg || (next_w < best_reg);
        sts.valid_ch        = 1'b1;
        case (item_reg.action)
            ACT_CHECK:   sts.action = ACT_CHECK;
            ACT_PERIOD:  sts.action = ACT_PERIOD;
            ACT_START_R: sts.action = ACT_START_R;
            ACT_START_O: sts.action = ACT_START_O;
            ACT_DISABLE: sts.action = ACT_DISABLE;
            default:     sts.action = action_t'(3'd7);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            repeat_reg <= '0;
            for (int i = 0; i < NumChannels; i++)
            begin
                period_reg[i]   <= '0;
                deadline_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.apply)
            begin
                case (item_reg.action)
                    ACT_PERIOD:
                        period_reg[item_reg.channel] <= item_reg.period_ms;
                    ACT_START_R, ACT_START_O:
                    begin
                        repeat_reg[item_reg.channel]   <= (item_reg.action == ACT_START_R);
                        deadline_reg[item_reg.channel] <= next_w;
                        active_reg[item_reg.channel]   <= 1'b1;
                    end
                    ACT_DISABLE:
                    begin
                        active_reg[item_reg.channel] <= 1'b0;
                        repeat_reg[item_reg.channel] <= 1'b0;
                    end
                    default:
                        ;
                endcase
            end
            if (cmd.fire_step && hit_w)
                active_reg[idx_reg] <= 1'b0;
            if (cmd.catch_step)
            begin
                if (period_reg[idx_reg] == '0)
                    deadline_reg[idx_reg] <= now_w;
                else if (sts.catch_done)
                    deadline_reg[idx_reg] <= cu_d_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= in_word;
            fire_reg  <= '0;
            stop_reg  <= 1'b0;
            start_reg <= 1'b0;
            reload_reg <= '0;
        end
        if (cmd.scan_clr)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else if (cmd.scan_step || cmd.fire_step || (cmd.catch_step && sts.catch_done))
        begin
            idx_reg <= idx_reg + ch_t'(1);
        end
        if (cmd.scan_step && active_reg[idx_reg]
            && (!found_reg || deadline_reg[idx_reg] < best_reg))
        begin
            found_reg <= 1'b1;
            best_reg  <= deadline_reg[idx_reg];
        end
        if ((cmd.fire_step || cmd.catch_start) && hit_w)
            fire_reg[idx_reg] <= 1'b1;
        if (cmd.catch_start)
        begin
            cu_d_reg    <= (period_reg[idx_reg] == '0) ? now_w
                           : deadline_reg[idx_reg] + period_reg[idx_reg];
            cu_wrap_reg <= 1'b0;
        end
        else if (cmd.catch_step && !sts.catch_done)
        begin
            cu_d_reg    <= cu_sum;
            cu_wrap_reg <= cu_ext[TimeBits];
        end
        if (cmd.set_stop)
            stop_reg <= 1'b1;
        if (cmd.set_start)
        begin
            start_reg <= 1'b1;
            dt_reg    <= (cmd.reload_sel_next ? next_w : best_reg) - now_w;
        end
        if (cmd.mul && start_reg)
        begin
            if (prod_w == '0)
                reload_reg <= '0;
            else if (prod_w > 40'h1_0000_0000)
                reload_reg <= 32'hFFFF_FFFF;
            else
                reload_reg <= 32'(prod_w - 40'd1);
        end
        if (cmd.out_load)
        begin
            out_reg.fire_mask        <= fire_reg;
            out_reg.hw_stop          <= stop_reg;
            out_reg.hw_start         <= start_reg;
            out_reg.reload_value     <= start_reg ? reload_reg : '0;
            out_reg.nearest_deadline <= found_reg ? best_reg : '0;
            out_reg.any_active       <= found_reg;
        end
    end

    assign out_word = out_reg;

    a_start_implies_stop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && start_reg |-> stop_reg)
        else $error("start without stop");
    a_fire_needs_stop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && (fire_reg != '0) |-> stop_reg)
        else $error("fire without stop");
    a_catch_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.catch_step && !sts.catch_done |=> cu_d_reg == $past(cu_sum))
        else $error("catch-up stalled");
endmodule
`default_nettype wire

// ===== rtl/multi_channel_deadline_timer_core.sv =====
// channel | direction | handshake    | word
// in      | input     | valid/stall  | in_word_t
// out     | output    | valid/stall  | out_word_t
// cfg     | input     | valid/ready  | ticks_per_ms (8 bits)
// out_valid rises once the 16-channel scans are done; a start adds a reload
// and a multiply step, and a check that fires also fires each due channel,
// steps each repeating one on by its period until caught up and scans again.
// in_stall is high from acceptance until idle; a waiting result holds the
// next item at the end of its final scan. Reset clears all channel state;
// ticks_per_ms resets to 2. cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none
module multi_channel_deadline_timer_core
    import mcdt_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  wire        out_stall,
    output out_word_t  out_data,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [7:0] cfg_data
);
    logic [7:0] ticks_reg;
    cmd_t cmd;
    sts_t sts;
    logic busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ticks_reg <= 8'd2;
        else if (cfg_valid && cfg_ready)
            ticks_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;

    mcdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_go    (in_valid && !busy),
        .out_free (!out_stall),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .out_vld  (out_valid)
    );

    mcdt_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_data),
        .ticks    (ticks_reg),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (out_data)
    );
endmodule
`default_nettype wire

// ===== tb/multi_channel_deadline_timer_core_tb.sv =====
`timescale 1ns / 1ps
module multi_channel_deadline_timer_core_tb;
    import mcdt_pkg::*;

    localparam logic [2:0] ACT_BAD5 = 3'd5;
    localparam logic [2:0] ACT_BAD6 = 3'd6;
    localparam logic [2:0] ACT_BAD7 = 3'd7;
    localparam int LIMIT = 1000000;
    localparam int SETTLE = 200;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    multi_channel_deadline_timer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // timer bank copy
    logic [31:0] chan_period [NumChannels];
    logic [31:0] chan_deadline [NumChannels];
    logic        chan_active [NumChannels];
    logic        chan_repeat [NumChannels];
    logic [7:0]  ticks;

    in_word_t  pending_words [$];
    out_word_t status_due [$];

    int  mismatches = 0;
    int  cycles = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  gap_max = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    bit  hold_req = 0;
    bit  hold_used = 0;
    logic [31:0] clock_ms;

    function automatic bit find_next(output logic [31:0] when);
        bit found;
        found = 0;
        when = '0;
        for (int i = 0; i < NumChannels; i++)
        begin
            if (chan_active[i] && (!found || chan_deadline[i] < when))
            begin
                when = chan_deadline[i];
                found = 1;
            end
        end
        return found;
    endfunction

    function automatic logic [31:0] reload_of(logic [31:0] dl, logic [31:0] now);
        logic [63:0] prod;
        prod = {32'b0, dl - now} * {56'b0, ticks};
        if (prod == 0)
            return '0;
        prod = prod - 1;
        return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    function automatic void advance_channel(int ch, logic [31:0] now);
        logic [31:0] p;
        logic [31:0] d;
        logic [63:0] n;
        p = chan_period[ch];
        if (p == 0)
        begin
            chan_deadline[ch] = now;
            return;
        end
        d = chan_deadline[ch] + p;
        if (d < now)
        begin
            n = {32'b0, now - d - 32'd1} / {32'b0, p} + 64'd1;
            d = d + 32'(n * {32'b0, p});
        end
        chan_deadline[ch] = d;
    endfunction

    function automatic out_word_t timer_status(in_word_t w);
        out_word_t   r;
        logic [31:0] first;
        logic [31:0] nxt;
        bit          had;
        r = '0;
        case (w.action)
            ACT_CHECK:
            begin
                if (find_next(first) && first <= w.now_ms)
                begin
                    r.hw_stop = 1;
                    for (int i = 0; i < NumChannels; i++)
                    begin
                        if (chan_active[i] && chan_deadline[i] <= w.now_ms)
                        begin
                            r.fire_mask[i] = 1'b1;
                            if (chan_repeat[i])
                                advance_channel(i, w.now_ms);
                            else
                                chan_active[i] = 0;
                        end
                    end
                    if (find_next(first))
                    begin
                        r.hw_start = 1;
                        r.reload_value = reload_of(first, w.now_ms);
                    end
                end
            end
            ACT_PERIOD:
                chan_period[w.channel] = w.period_ms;
            ACT_START_R, ACT_START_O:
            begin
                had = find_next(first);
                nxt = w.now_ms + chan_period[w.channel];
                chan_repeat[w.channel] = (w.action == ACT_START_R);
                chan_deadline[w.channel] = nxt;
                chan_active[w.channel] = 1;
                if (!had || nxt < first)
                begin
                    r.hw_stop = 1;
                    r.hw_start = 1;
                    r.reload_value = reload_of(nxt, w.now_ms);
                end
            end
            ACT_DISABLE:
            begin
                chan_active[w.channel] = 0;
                chan_repeat[w.channel] = 0;
            end
            default: ;
        endcase
        r.any_active = find_next(first);
        r.nearest_deadline = r.any_active ? first : '0;
        return r;
    endfunction

    task automatic push(logic [2:0] a, logic [3:0] c, logic [31:0] p, logic [31:0] n);
        in_word_t w;
        w.action = a;
        w.channel = c;
        w.period_ms = p;
        w.now_ms = n;
        pending_words.push_back(w);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_ticks(logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ticks = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int k;
        logic [3:0] ch;
        for (int j = 0; j < count; j++)
        begin
            k = $urandom_range(0, 99);
            if (k < 30)
            begin
                clock_ms = clock_ms + $urandom_range(0, 40);
                push(ACT_CHECK, 4'($urandom), $urandom, clock_ms);
            end
            else if (k < 45)
            begin
                ch = 4'($urandom);
                // low channels repeat, so keep their periods short
                if (!ch[3])
                    push(ACT_PERIOD, ch, $urandom_range(0, 40), $urandom);
                else if ($urandom_range(0, 1))
                    push(ACT_PERIOD, ch, $urandom, $urandom);
                else
                    push(ACT_PERIOD, ch, $urandom_range(0, 60), $urandom);
            end
            else if (k < 65)
                push(ACT_START_R, {1'b0, 3'($urandom)}, $urandom, clock_ms);
            else if (k < 80)
            begin
                ch = 4'($urandom);
                if (ch[3] && $urandom_range(0, 2) == 0)
                    push(ACT_START_O, ch, $urandom, $urandom);
                else
                    push(ACT_START_O, ch, $urandom, clock_ms);
            end
            else if (k < 90)
                push(ACT_DISABLE, 4'($urandom), $urandom, $urandom);
            else if (k < 95)
                push(3'($urandom_range(ACT_BAD5, ACT_BAD7)), 4'($urandom), $urandom, $urandom);
            else
            begin
                clock_ms = clock_ms + $urandom_range(0, 10);
                push(ACT_CHECK, 4'($urandom), $urandom, clock_ms);
            end
        end
    endtask

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (in_valid)
                status_due.push_back(timer_status(in_data));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                in_data <= pending_words.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= $urandom_range(0, gap_max);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", out_data);
            end
            else
            begin
                e = status_due.pop_front();
                if (out_data !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp fire %h stop %b start %b reload %h near %h act %b",
                            e.fire_mask, e.hw_stop, e.hw_start, e.reload_value,
                            e.nearest_deadline, e.any_active,
                            "\n          got fire %h stop %b start %b reload %h near %h act %b",
                            out_data.fire_mask, out_data.hw_stop, out_data.hw_start,
                            out_data.reload_value, out_data.nearest_deadline,
                            out_data.any_active);
                end
            end
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_stall = 0;
        cfg_valid = 0;
        cfg_data = '0;
        ticks = 8'd2;
        for (int i = 0; i < NumChannels; i++)
        begin
            chan_period[i] = '0;
            chan_deadline[i] = '0;
            chan_active[i] = 0;
            chan_repeat[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);

        write_ticks(8'd1);
        push(ACT_CHECK, 4'd0, 32'd0, 32'd0);
        push(ACT_BAD5, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(ACT_BAD6, 4'd3, 32'd7, 32'd9);
        push(ACT_BAD7, 4'd12, 32'h8000_0000, 32'h1234_5678);
        push(ACT_PERIOD, 4'd15, 32'hFFFF_FFFF, 32'd0);
        push(ACT_START_O, 4'd15, 32'd0, 32'hFFFF_FFFF);
        push(ACT_PERIOD, 4'd8, 32'd0, 32'd0);
        push(ACT_START_O, 4'd8, 32'd0, 32'd0);
        push(ACT_CHECK, 4'd0, 32'd0, 32'd0);
        push(ACT_DISABLE, 4'd15, 32'd0, 32'd0);
        push(ACT_CHECK, 4'd0, 32'd0, 32'd50);
        push(ACT_PERIOD, 4'd0, 32'd0, 32'd0);
        push(ACT_START_R, 4'd0, 32'd0, 32'd100);
        push(ACT_CHECK, 4'd0, 32'd0, 32'd105);
        push(ACT_PERIOD, 4'd1, 32'd10, 32'd0);
        push(ACT_START_R, 4'd1, 32'd0, 32'd100);
        push(ACT_START_R, 4'd1, 32'd0, 32'd100);
        push(ACT_CHECK, 4'd0, 32'd0, 32'd135);
        push(ACT_START_O, 4'd1, 32'd0, 32'd140);
        push(ACT_CHECK, 4'd0, 32'd0, 32'd160);
        push(ACT_DISABLE, 4'd0, 32'd0, 32'd0);
        push(ACT_DISABLE, 4'd1, 32'd0, 32'd0);
        push(ACT_CHECK, 4'd0, 32'd0, 32'd200);
        wait_idle();

        clock_ms = 32'd300;
        write_ticks(8'd255);
        gap_max = 0;
        stall_pct = 0;
        random_phase(140);
        wait_idle();

        write_ticks(8'd2);
        gap_max = 6;
        stall_pct = 30;
        hold_req = 1;
        random_phase(140);
        wait_idle();

        write_ticks(8'($urandom_range(3, 254)));
        gap_max = 3;
        stall_pct = 60;
        random_phase(140);
        wait_idle();

        write_ticks(8'd1);
        gap_max = 10;
        stall_pct = 15;
        random_phase(130);
        wait_idle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== multi_channel_deadline_timer_core.f =====
rtl/mcdt_pkg.sv
rtl/mcdt_ctrl.sv
rtl/mcdt_dp.sv
rtl/multi_channel_deadline_timer_core.sv
tb/multi_channel_deadline_timer_core_tb.sv
